[rtl/core/trsc_pkg.sv]
// ----------------------------------------------------------------------------
// trsc_pkg
// Shared types, register map and rotor wiring tables for the three-rotor
// substitution cipher.
// ----------------------------------------------------------------------------
package trsc_pkg;

	localparam int unsigned RotorSize = 26;

	typedef logic [4:0] letter_t;
	typedef logic [7:0] byte_t;

	// Register map, index = paddr[3:2].
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_START_FIRST  = 2'd0;
	localparam reg_idx_t REG_START_SECOND = 2'd1;
	localparam reg_idx_t REG_START_THIRD  = 2'd2;
	localparam reg_idx_t REG_DECRYPT_MODE = 2'd3;

	localparam logic CMD_TRANSFORM = 1'b0;
	localparam logic CMD_LOAD      = 1'b1;

	localparam byte_t CHAR_A = 8'h41;
	localparam byte_t CHAR_Z = 8'h5A;

	localparam letter_t LAST_POS = 5'd25;

	// Forward wirings of rotors I, II and III.
	localparam letter_t WIRE_FWD [3][RotorSize] = '{
		'{5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25,
		  5'd13, 5'd19, 5'd14, 5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15,
		  5'd0, 5'd8, 5'd1, 5'd17, 5'd2, 5'd9},
		'{5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1,
		  5'd11, 5'd7, 5'd22, 5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13,
		  5'd15, 5'd24, 5'd5, 5'd21, 5'd14, 5'd4},
		'{5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19,
		  5'd23, 5'd21, 5'd25, 5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0,
		  5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14}
	};

	// Inverse wirings of rotors I, II and III.
	localparam letter_t WIRE_INV [3][RotorSize] = '{
		'{5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25,
		  5'd1, 5'd4, 5'd2, 5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18, 5'd11,
		  5'd17, 5'd8, 5'd13, 5'd16, 5'd14, 5'd9},
		'{5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1,
		  5'd3, 5'd10, 5'd14, 5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4, 5'd13,
		  5'd7, 5'd23, 5'd12, 5'd8, 5'd21, 5'd18},
		'{5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4,
		  5'd20, 5'd5, 5'd21, 5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9,
		  5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12}
	};

	// Reduces a 5-bit value below 32 into 0..25.
	function automatic letter_t mod26(input letter_t v);
		mod26 = (v >= 5'd26) ? letter_t'(v - 5'd26) : v;
	endfunction

	// (a - b) mod 26 for a, b in 0..25.
	function automatic letter_t sub26(input letter_t a, input letter_t b);
		sub26 = (a >= b) ? letter_t'(a - b) : letter_t'(a + 5'd26 - b);
	endfunction

	// (a + b) mod 26 for a, b in 0..25.
	function automatic letter_t add26(input letter_t a, input letter_t b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		add26 = (s >= 6'd26) ? letter_t'(s - 6'd26) : letter_t'(s);
	endfunction

endpackage

[rtl/core/three_rotor_substitution_cipher.sv]
// ----------------------------------------------------------------------------
// three_rotor_substitution_cipher
// Byte stream cipher with three fixed-wiring rotors stepping like an odometer,
// no reflector and no plugboard. Letters A-Z are substituted, other bytes pass.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                     Payload
//  -------   ---------------------------   ---------------------------------
//  item      item_valid / item_ready       command, in_char
//  result    result_valid / result_ready   out_char, pos_first/second/third
//  config    APB psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// For each transaction, the rotor lookups and the mod-26
// step are computed from the rotor positions and the accepted item, and land
// in the result register at the accepting edge. A new item is accepted every
// cycle while the result register is empty or being drained in that cycle.
// A stalled result holds the input side only until it is taken.
// Reset clears the rotor positions, the start registers and the mode.
// ----------------------------------------------------------------------------
module three_rotor_substitution_cipher (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic                 command,
	input  trsc_pkg::byte_t      in_char,

	output logic                 result_valid,
	input  logic                 result_ready,
	output trsc_pkg::byte_t      out_char,
	output trsc_pkg::letter_t    pos_first,
	output trsc_pkg::letter_t    pos_second,
	output trsc_pkg::letter_t    pos_third,

	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import trsc_pkg::*;

	letter_t start_first_q, start_second_q, start_third_q;
	logic    decrypt_q;
	letter_t rot1_q, rot2_q, rot3_q;

	logic     item_acc;
	logic     cfg_wr;
	reg_idx_t cfg_idx;

	letter_t x_in, e1, e2, e3, d3, d2, d1, sub_res;
	logic    is_letter;
	byte_t   char_nxt;
	letter_t rot1_nxt, rot2_nxt, rot3_nxt;

	assign item_ready = !result_valid || result_ready;
	assign item_acc   = item_valid && item_ready;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_first_q  <= '0;
			start_second_q <= '0;
			start_third_q  <= '0;
			decrypt_q      <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_START_FIRST:  start_first_q  <= pwdata[4:0];
				REG_START_SECOND: start_second_q <= pwdata[4:0];
				REG_START_THIRD:  start_third_q  <= pwdata[4:0];
				REG_DECRYPT_MODE: decrypt_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_START_FIRST:  prdata = {27'd0, start_first_q};
			REG_START_SECOND: prdata = {27'd0, start_second_q};
			REG_START_THIRD:  prdata = {27'd0, start_third_q};
			REG_DECRYPT_MODE: prdata = {31'd0, decrypt_q};
			default:          prdata = '0;
		endcase
	end

	// ---------------- substitution ----------------
	assign is_letter = (in_char >= CHAR_A) && (in_char <= CHAR_Z);
	assign x_in      = letter_t'(in_char - CHAR_A);

	// The index is only meaningful for letters; clamp it to stay in range.
	always_comb begin
		letter_t xs;
		xs = is_letter ? x_in : 5'd0;
		e1 = WIRE_FWD[0][sub26(xs, rot1_q)];
		e2 = WIRE_FWD[1][sub26(e1, rot2_q)];
		e3 = WIRE_FWD[2][sub26(e2, rot3_q)];
		d3 = add26(WIRE_INV[2][xs], rot3_q);
		d2 = add26(WIRE_INV[1][d3], rot2_q);
		d1 = add26(WIRE_INV[0][d2], rot1_q);
		sub_res = decrypt_q ? d1 : e3;
	end

	always_comb begin
		char_nxt = in_char;
		rot1_nxt = rot1_q;
		rot2_nxt = rot2_q;
		rot3_nxt = rot3_q;
		if (command == CMD_LOAD) begin
			rot1_nxt = mod26(start_first_q);
			rot2_nxt = mod26(start_second_q);
			rot3_nxt = mod26(start_third_q);
		end else begin
			if (is_letter) begin
				char_nxt = byte_t'({3'd0, sub_res}) + CHAR_A;
			end
			// Odometer stepping; positions always stay in 0..25.
			if (rot1_q == LAST_POS) begin
				rot1_nxt = '0;
				if (rot2_q == LAST_POS) begin
					rot2_nxt = '0;
					rot3_nxt = (rot3_q == LAST_POS) ? 5'd0 : letter_t'(rot3_q + 5'd1);
				end else begin
					rot2_nxt = letter_t'(rot2_q + 5'd1);
				end
			end else begin
				rot1_nxt = letter_t'(rot1_q + 5'd1);
			end
		end
	end

	// ---------------- state and result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot1_q       <= '0;
			rot2_q       <= '0;
			rot3_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			if (item_acc) begin
				rot1_q       <= rot1_nxt;
				rot2_q       <= rot2_nxt;
				rot3_q       <= rot3_nxt;
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			out_char   <= char_nxt;
			pos_first  <= rot1_nxt;
			pos_second <= rot2_nxt;
			pos_third  <= rot3_nxt;
		end
	end

endmodule
